FILE: hw/rtl/multiplexed_seven_segment_clock_core_macros.svh
// Assertion helpers shared by the clock core modules.
// MSC_ASSERT expects signals named clk and rst in the using module; MSC_ASSERT_ALWAYS only clk.
`ifndef MULTIPLEXED_SEVEN_SEGMENT_CLOCK_CORE_MACROS_SVH
`define MULTIPLEXED_SEVEN_SEGMENT_CLOCK_CORE_MACROS_SVH

// Check a property at every clock edge outside reset.
`define MSC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("clock core check failed");

// Check a property at every clock edge, reset included.
`define MSC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("clock core check failed");

`endif

FILE: hw/rtl/msc_pkg.sv
package msc_pkg;

  // Request codes on the input channel.
  localparam logic [2:0] REQ_TIME    = 3'd0;
  localparam logic [2:0] REQ_REFRESH = 3'd1;
  localparam logic [2:0] REQ_FLASH   = 3'd2;
  localparam logic [2:0] REQ_MODE    = 3'd3;
  localparam logic [2:0] REQ_INC     = 3'd4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_TIME,
    OP_REFRESH,
    OP_FLASH,
    OP_MODE,
    OP_INC
  } op_t;

  typedef struct packed {
    op_t  op;
    logic fast;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } qwr_t;

  // Configuration register indexes and widths.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SLOW_LIMIT,
    CFG_FAST_LIMIT,
    CFG_REFRESH_LIMIT,
    CFG_FLASH_LIMIT
  } cfg_reg_t;

  localparam int ADV_W     = 10;
  localparam int REFRESH_W = 8;
  localparam int FLASH_W   = 16;

  localparam logic [ADV_W-1:0]     SLOW_LIMIT_RST    = 10'd30;
  localparam logic [ADV_W-1:0]     FAST_LIMIT_RST    = 10'd1;
  localparam logic [REFRESH_W-1:0] REFRESH_LIMIT_RST = 8'd8;
  localparam logic [FLASH_W-1:0]   FLASH_LIMIT_RST   = 16'd1000;
  localparam logic [FLASH_W-1:0]   FLASH_MAX         = 16'hFFFF;

  localparam int QUEUE_DEPTH = 2;

  typedef logic [3:0] digit_t;
  typedef digit_t [3:0] digits_t;

  localparam digits_t DIGITS_RST = {4'd1, 4'd2, 4'd0, 4'd0};
  localparam logic [1:0] EDIT_HOME = 2'd3;
  localparam logic [1:0] DP_POS    = 2'd2;
  localparam logic [7:0] DP_MASK   = 8'h80;

  localparam logic [7:0] SEG_TABLE [16] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h67, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef struct packed {
    logic [3:0] enable;
    logic [7:0] segment;
  } drive_t;

  typedef struct packed {
    logic [3:0] digit_enable;
    logic [7:0] segment_pattern;
    logic [3:0] minutes_units;
    logic [2:0] minutes_tens;
    logic [3:0] hours_units;
    logic [1:0] hours_tens;
    logic       in_setting_mode;
    logic [1:0] selected_position;
  } result_t;

  function automatic drive_t drive_digit(digits_t d, logic [1:0] pos);
    drive_t r;
    r.enable  = 4'(1) << pos;
    r.segment = SEG_TABLE[d[pos]] | ((pos == DP_POS) ? DP_MASK : 8'h00);
    return r;
  endfunction

  // One minute forward with carries, 23:59 wraps to 00:00.
  function automatic digits_t advance_minute(digits_t d);
    digits_t r;
    r = d;
    r[0] = r[0] + 4'd1;
    if (r[0] == 4'd10) begin
      r[0] = '0;
      r[1] = r[1] + 4'd1;
    end
    if (r[1] == 4'd6) begin
      r[1] = '0;
      r[2] = r[2] + 4'd1;
    end
    if (r[2] == 4'd10) begin
      r[2] = '0;
      r[3] = r[3] + 4'd1;
    end
    if (r[3] == 4'd2 && r[2] == 4'd4) r = '0;
    return r;
  endfunction

  // Bump one digit, then carry and wrap at 24 hours.
  function automatic digits_t step_selected(digits_t d, logic [1:0] pos);
    digits_t r;
    r = d;
    r[pos] = r[pos] + 4'd1;
    if (r[0] > 4'd9) begin
      r[0] = '0;
      r[1] = r[1] + 4'd1;
    end
    if (r[1] >= 4'd6) begin
      r[1] = '0;
      r[2] = r[2] + 4'd1;
    end
    if (r[2] > 4'd9) begin
      r[2] = '0;
      r[3] = r[3] + 4'd1;
    end
    if ((r[3] == 4'd2 && r[2] >= 4'd4) || r[3] > 4'd2) r = '0;
    return r;
  endfunction

endpackage

FILE: hw/rtl/msc_if.sv
interface msc_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic       fast_button_held;

  modport source (output valid, output req_type, output fast_button_held, input ready);
  modport sink (input valid, input req_type, input fast_button_held, output ready);
endinterface

interface msc_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] digit_enable;
  logic [7:0] segment_pattern;
  logic [3:0] minutes_units;
  logic [2:0] minutes_tens;
  logic [3:0] hours_units;
  logic [1:0] hours_tens;
  logic       in_setting_mode;
  logic [1:0] selected_position;

  modport source (
    output valid, output digit_enable, output segment_pattern, output minutes_units,
    output minutes_tens, output hours_units, output hours_tens, output in_setting_mode,
    output selected_position, input ready
  );
  modport sink (
    input valid, input digit_enable, input segment_pattern, input minutes_units,
    input minutes_tens, input hours_units, input hours_tens, input in_setting_mode,
    input selected_position, output ready
  );
endinterface

FILE: hw/rtl/msc_front.sv
module msc_front (
  msc_req_if.sink       req,
  input  logic          q_full,
  output msc_pkg::qwr_t qwr
);
  import msc_pkg::*;

  op_t op;

  // Classify the request code; unused codes become no-ops.
  always_comb begin
    case (req.req_type)
      REQ_TIME:    op = OP_TIME;
      REQ_REFRESH: op = OP_REFRESH;
      REQ_FLASH:   op = OP_FLASH;
      REQ_MODE:    op = OP_MODE;
      REQ_INC:     op = OP_INC;
      default:     op = OP_NONE;
    endcase
  end

  assign req.ready    = !q_full;
  assign qwr.push     = req.valid && !q_full;
  assign qwr.cmd.op   = op;
  assign qwr.cmd.fast = req.fast_button_held;

endmodule

FILE: hw/rtl/msc_queue.sv
`include "multiplexed_seven_segment_clock_core_macros.svh"

module msc_queue (
  input  logic          clk,
  input  logic          rst,
  input  msc_pkg::qwr_t qwr,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output msc_pkg::cmd_t head
);
  import msc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (qwr.push) mem[wr_ptr] <= qwr.cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (qwr.push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (qwr.push && !pop) count <= count + 1'b1;
      else if (pop && !qwr.push) count <= count - 1'b1;
    end
  end

  `MSC_ASSERT(a_count_bound, count <= CNT_W'(QUEUE_DEPTH))
  `MSC_ASSERT(a_pop_nonempty, pop |-> head_valid)

endmodule

FILE: hw/rtl/msc_back.sv
`include "multiplexed_seven_segment_clock_core_macros.svh"

module msc_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [msc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [msc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              head_valid,
  input  msc_pkg::cmd_t                     head,
  output logic                              pop,
  msc_res_if.source                         res
);
  import msc_pkg::*;

  logic [ADV_W-1:0]     slow_limit;
  logic [ADV_W-1:0]     fast_limit;
  logic [REFRESH_W-1:0] refresh_limit;
  logic [FLASH_W-1:0]   flash_limit;

  digits_t              digits, digits_next;
  logic [ADV_W-1:0]     advance_count, advance_count_next;
  logic [REFRESH_W-1:0] refresh_count, refresh_count_next;
  logic [FLASH_W-1:0]   flash_count, flash_count_next;
  logic [1:0]           scan_position, scan_position_next;
  logic                 setting_flag, setting_flag_next;
  logic [1:0]           edit_position, edit_position_next;
  logic [3:0]           enable_latch, enable_latch_next;
  logic [7:0]           segment_latch, segment_latch_next;

  logic [ADV_W-1:0]     adv_sum;
  logic [ADV_W-1:0]     adv_limit;
  logic [REFRESH_W-1:0] ref_sum;
  drive_t               drv_scan;
  drive_t               drv_edit;

  logic                 out_valid;
  result_t              out_data;

  assign pop = head_valid && (!out_valid || res.ready);

  assign adv_sum   = advance_count + 1'b1;
  assign adv_limit = head.fast ? fast_limit : slow_limit;
  assign ref_sum   = refresh_count + 1'b1;
  assign drv_scan  = drive_digit(digits, scan_position);
  assign drv_edit  = drive_digit(digits, edit_position);

  always_comb begin
    digits_next        = digits;
    advance_count_next = advance_count;
    refresh_count_next = refresh_count;
    flash_count_next   = flash_count;
    scan_position_next = scan_position;
    setting_flag_next  = setting_flag;
    edit_position_next = edit_position;
    enable_latch_next  = enable_latch;
    segment_latch_next = segment_latch;
    if (pop) begin
      case (head.op)
        OP_TIME: begin
          // counting pauses while setting
          if (!setting_flag) begin
            if (adv_sum >= adv_limit) begin
              advance_count_next = '0;
              digits_next        = advance_minute(digits);
            end else begin
              advance_count_next = adv_sum;
            end
          end
        end
        OP_REFRESH: begin
          if (ref_sum >= refresh_limit) begin
            refresh_count_next = '0;
            // blank the digit under edit in the scan
            if (scan_position != edit_position || !setting_flag) begin
              enable_latch_next  = drv_scan.enable;
              segment_latch_next = drv_scan.segment;
            end
            scan_position_next = scan_position + 1'b1;
            // flash: show the edited digit once
            if (flash_count >= flash_limit) begin
              enable_latch_next  = drv_edit.enable;
              segment_latch_next = drv_edit.segment;
              flash_count_next   = '0;
            end
          end else begin
            refresh_count_next = ref_sum;
          end
        end
        OP_FLASH: begin
          if (setting_flag && flash_count != FLASH_MAX) flash_count_next = flash_count + 1'b1;
        end
        OP_MODE: begin
          if (!setting_flag) begin
            setting_flag_next = 1'b1;
          end else if (edit_position == '0) begin
            setting_flag_next  = 1'b0;
            edit_position_next = EDIT_HOME;
          end else begin
            edit_position_next = edit_position - 1'b1;
          end
        end
        OP_INC: begin
          if (setting_flag) digits_next = step_selected(digits, edit_position);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_limit    <= SLOW_LIMIT_RST;
      fast_limit    <= FAST_LIMIT_RST;
      refresh_limit <= REFRESH_LIMIT_RST;
      flash_limit   <= FLASH_LIMIT_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        CFG_SLOW_LIMIT:    slow_limit    <= cfg_data[ADV_W-1:0];
        CFG_FAST_LIMIT:    fast_limit    <= cfg_data[ADV_W-1:0];
        CFG_REFRESH_LIMIT: refresh_limit <= cfg_data[REFRESH_W-1:0];
        CFG_FLASH_LIMIT:   flash_limit   <= cfg_data[FLASH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digits        <= DIGITS_RST;
      advance_count <= '0;
      refresh_count <= '0;
      flash_count   <= '0;
      scan_position <= '0;
      setting_flag  <= 1'b0;
      edit_position <= EDIT_HOME;
      enable_latch  <= '0;
      segment_latch <= '0;
      out_valid     <= 1'b0;
    end else begin
      digits        <= digits_next;
      advance_count <= advance_count_next;
      refresh_count <= refresh_count_next;
      flash_count   <= flash_count_next;
      scan_position <= scan_position_next;
      setting_flag  <= setting_flag_next;
      edit_position <= edit_position_next;
      enable_latch  <= enable_latch_next;
      segment_latch <= segment_latch_next;
      if (pop) out_valid <= 1'b1;
      else if (res.ready) out_valid <= 1'b0;
    end
  end

  // Result register: snapshot of the state left by the item.
  always_ff @(posedge clk) begin
    if (pop) begin
      out_data.digit_enable      <= enable_latch_next;
      out_data.segment_pattern   <= segment_latch_next;
      out_data.minutes_units     <= digits_next[0];
      out_data.minutes_tens      <= digits_next[1][2:0];
      out_data.hours_units       <= digits_next[2];
      out_data.hours_tens        <= digits_next[3][1:0];
      out_data.in_setting_mode   <= setting_flag_next;
      out_data.selected_position <= edit_position_next;
    end
  end

  assign res.valid             = out_valid;
  assign res.digit_enable      = out_data.digit_enable;
  assign res.segment_pattern   = out_data.segment_pattern;
  assign res.minutes_units     = out_data.minutes_units;
  assign res.minutes_tens      = out_data.minutes_tens;
  assign res.hours_units       = out_data.hours_units;
  assign res.hours_tens        = out_data.hours_tens;
  assign res.in_setting_mode   = out_data.in_setting_mode;
  assign res.selected_position = out_data.selected_position;

  `MSC_ASSERT_ALWAYS(a_reset_idle, rst |=> !out_valid)
  `MSC_ASSERT(a_enable_onehot0, $onehot0(enable_latch))
  `MSC_ASSERT(a_home_when_running, !setting_flag |-> edit_position == EDIT_HOME)
  `MSC_ASSERT(a_time_legal, digits[0] <= 4'd9 && digits[1] <= 4'd5 && digits[2] <= 4'd9 && (digits[3] < 4'd2 || (digits[3] == 4'd2 && digits[2] <= 4'd3)))
  `MSC_ASSERT(a_paused_time, $past(setting_flag) && setting_flag && $past(head.op) == OP_TIME |-> $stable(digits))

endmodule

FILE: hw/rtl/multiplexed_seven_segment_clock_core.sv
// A transfer on req goes into the queue, then into the result register that drives res.
// Throughput: one request per cycle while res is not stalled; a two-entry queue splits decode from execution.
// The back end executes each request, digit carry chain included.
// Reset (rst, synchronous): time 12:00, counters and latches cleared, edit position 3,
// limits 30 / 1 / 8 / 1000, queue and result register empty; no clearing pass.
module multiplexed_seven_segment_clock_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [msc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [msc_pkg::CFG_DATA_W-1:0]  cfg_data,
  msc_req_if.sink                         req,
  msc_res_if.source                       res
);
  import msc_pkg::*;

  qwr_t qwr;
  logic q_full;
  logic head_valid;
  cmd_t head;
  logic pop;

  // Front end: accept the transfer and classify the request code.
  msc_front u_front (
    .req    (req),
    .q_full (q_full),
    .qwr    (qwr)
  );

  // Decoupling queue: front keeps accepting, until the queue fills, while the result waits on res.
  msc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .qwr        (qwr),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back end: advance the clock, scan the display, walk setting mode,
  // and hold the result in an output register until it is taken.
  msc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .res        (res)
  );

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import msc_pkg::*;

  // Spare request codes: the block must leave its state alone on these.
  localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

  localparam int HOLD_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int FLASH_FLOOD  = 60;
  localparam int PHASE_EVENTS = 150;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  msc_req_if req_ch ();
  msc_res_if res_ch ();

  multiplexed_seven_segment_clock_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .res       (res_ch)
  );

  // Shared run control and bookkeeping.
  bit idling;
  bit hold_off;
  int errors;
  int sent_count;
  int checked_count;
  int cycle_count;
  int minute_steps;
  int midnight_wraps;
  int scan_steps;
  int flash_reveals;

  // Display snapshots the block should produce, oldest first.
  result_t pending_displays[$];

  // Clock state as the testbench tracks it.
  logic [3:0]  cur_digits [4];
  logic [9:0]  adv_ticks;
  logic [7:0]  refresh_ticks;
  logic [15:0] flash_ticks;
  logic [1:0]  scan_idx;
  logic        setting_on;
  logic [1:0]  edit_idx;
  logic [3:0]  enable_q;
  logic [7:0]  segment_q;
  logic [9:0]  slow_lim;
  logic [9:0]  fast_lim;
  logic [7:0]  refresh_lim;
  logic [15:0] flash_lim;

  // ---------------------------------------------------------------------------
  // Clock and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Kill the run once the cycle count reaches the limit; a healthy run ends far below this.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: watchdog expired, %0d displays still owed", $time,
               pending_displays.size());
      $display("multiplexed_seven_segment_clock_core test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Clock model: tracks digits, prescalers, scan and setting mode
  // ---------------------------------------------------------------------------
  task automatic reset_model();
    cur_digits    = '{4'd0, 4'd0, 4'd2, 4'd1};
    adv_ticks     = '0;
    refresh_ticks = '0;
    flash_ticks   = '0;
    scan_idx      = '0;
    setting_on    = 1'b0;
    edit_idx      = EDIT_HOME;
    enable_q      = '0;
    segment_q     = '0;
    slow_lim      = 10'd30;
    fast_lim      = 10'd1;
    refresh_lim   = 8'd8;
    flash_lim     = 16'd1000;
  endtask

  function automatic logic [7:0] segments_for(input logic [3:0] d);
    case (d)
      4'd0: return 8'h3F;
      4'd1: return 8'h06;
      4'd2: return 8'h5B;
      4'd3: return 8'h4F;
      4'd4: return 8'h66;
      4'd5: return 8'h6D;
      4'd6: return 8'h7D;
      4'd7: return 8'h07;
      4'd8: return 8'h7F;
      4'd9: return 8'h67;
      default: return 8'h00;
    endcase
  endfunction

  // Load both latches for one digit; the hours-units digit carries the point.
  task automatic light_digit(input logic [1:0] pos);
    enable_q  = 4'b0001 << pos;
    segment_q = segments_for(cur_digits[pos]) | ((pos == DP_POS) ? DP_MASK : 8'h00);
  endtask

  task automatic tick_minute();
    minute_steps++;
    cur_digits[0] = cur_digits[0] + 4'd1;
    if (cur_digits[0] == 4'd10) begin
      cur_digits[0] = '0;
      cur_digits[1] = cur_digits[1] + 4'd1;
    end
    if (cur_digits[1] == 4'd6) begin
      cur_digits[1] = '0;
      cur_digits[2] = cur_digits[2] + 4'd1;
    end
    if (cur_digits[2] == 4'd10) begin
      cur_digits[2] = '0;
      cur_digits[3] = cur_digits[3] + 4'd1;
    end
    if (cur_digits[3] == 4'd2 && cur_digits[2] == 4'd4) begin
      cur_digits = '{4'd0, 4'd0, 4'd0, 4'd0};
      midnight_wraps++;
    end
  endtask

  // Increment the digit under edit; carries run upward, anything past 23 clears all.
  task automatic bump_edit_digit();
    cur_digits[edit_idx] = cur_digits[edit_idx] + 4'd1;
    if (cur_digits[0] > 4'd9) begin
      cur_digits[0] = '0;
      cur_digits[1] = cur_digits[1] + 4'd1;
    end
    if (cur_digits[1] >= 4'd6) begin
      cur_digits[1] = '0;
      cur_digits[2] = cur_digits[2] + 4'd1;
    end
    if (cur_digits[2] > 4'd9) begin
      cur_digits[2] = '0;
      cur_digits[3] = cur_digits[3] + 4'd1;
    end
    if ((cur_digits[3] == 4'd2 && cur_digits[2] >= 4'd4) || cur_digits[3] > 4'd2) begin
      cur_digits = '{4'd0, 4'd0, 4'd0, 4'd0};
      midnight_wraps++;
    end
  endtask

  // One multiplex step: skip the digit under edit in setting mode, then reveal it once the
  // flash count has reached its limit (even outside setting mode).
  task automatic scan_next();
    scan_steps++;
    if (scan_idx != edit_idx || !setting_on) light_digit(scan_idx);
    scan_idx = scan_idx + 2'd1;
    if (flash_ticks >= flash_lim) begin
      light_digit(edit_idx);
      flash_ticks = '0;
      flash_reveals++;
    end
  endtask

  // Apply one accepted request and queue the display it should produce.
  task automatic apply_event(input logic [2:0] code, input logic fast);
    result_t want;
    case (code)
      REQ_TIME: begin
        if (!setting_on) begin
          adv_ticks = adv_ticks + 10'd1;
          if (adv_ticks >= (fast ? fast_lim : slow_lim)) begin
            adv_ticks = '0;
            tick_minute();
          end
        end
      end
      REQ_REFRESH: begin
        refresh_ticks = refresh_ticks + 8'd1;
        if (refresh_ticks >= refresh_lim) begin
          scan_next();
          refresh_ticks = '0;
        end
      end
      REQ_FLASH: begin
        if (setting_on && flash_ticks != FLASH_MAX) flash_ticks = flash_ticks + 16'd1;
      end
      REQ_MODE: begin
        if (!setting_on) begin
          setting_on = 1'b1;
        end else if (edit_idx == 2'd0) begin
          setting_on = 1'b0;
          edit_idx   = EDIT_HOME;
        end else begin
          edit_idx = edit_idx - 2'd1;
        end
      end
      REQ_INC: begin
        if (setting_on) bump_edit_digit();
      end
      default: ;
    endcase
    want.digit_enable      = enable_q;
    want.segment_pattern   = segment_q;
    want.minutes_units     = cur_digits[0];
    want.minutes_tens      = cur_digits[1][2:0];
    want.hours_units       = cur_digits[2];
    want.hours_tens        = cur_digits[3][1:0];
    want.in_setting_mode   = setting_on;
    want.selected_position = edit_idx;
    pending_displays.push_back(want);
  endtask

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Offer one request, optionally after a short bubble, and hold it until the
  // transfer happens. Valid stays high afterwards; the next call or quiesce
  // decides what it does at the following falling edge.
  task automatic send_event(input logic [2:0] code, input logic fast);
    int gap;
    if (idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      @(negedge clk);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_ch.valid            <= 1'b1;
    req_ch.req_type         <= code;
    req_ch.fast_button_held <= fast;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    apply_event(code, fast);
    sent_count++;
  endtask

  // Drop valid and wait until every owed display has been seen.
  task automatic quiesce();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_displays.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one limit register; only called while the block is idle.
  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_SLOW_LIMIT:    slow_lim    = val[9:0];
      CFG_FAST_LIMIT:    fast_lim    = val[9:0];
      CFG_REFRESH_LIMIT: refresh_lim = val[7:0];
      CFG_FLASH_LIMIT:   flash_lim   = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_limits(input logic [15:0] slow, input logic [15:0] fast,
                            input logic [15:0] refresh, input logic [15:0] flash);
    write_reg(CFG_SLOW_LIMIT, slow);
    write_reg(CFG_FAST_LIMIT, fast);
    write_reg(CFG_REFRESH_LIMIT, refresh);
    write_reg(CFG_FLASH_LIMIT, flash);
  endtask

  // Walk setting mode and press increment until each digit matches the goal.
  // Carries can disturb digits already set; the model follows whatever happens.
  task automatic set_time(input logic [3:0] ht, input logic [3:0] hu,
                          input logic [3:0] mt, input logic [3:0] mu, input bit sprinkle);
    logic [3:0] goal [4];
    int pos;
    int tries;
    goal = '{mu, mt, hu, ht};
    while (setting_on) send_event(REQ_MODE, 1'($urandom_range(0, 1)));
    send_event(REQ_MODE, 1'($urandom_range(0, 1)));
    for (pos = 3; pos >= 0; pos--) begin
      tries = 0;
      while (cur_digits[pos] != goal[pos] && tries < 12) begin
        send_event(REQ_INC, 1'($urandom_range(0, 1)));
        if (sprinkle && $urandom_range(0, 2) == 0)
          send_event($urandom_range(0, 1) ? REQ_REFRESH : REQ_FLASH, 1'($urandom_range(0, 1)));
        tries++;
      end
      // Step to the next digit; at minutes units this leaves setting mode.
      send_event(REQ_MODE, 1'($urandom_range(0, 1)));
    end
  endtask

  function automatic logic [2:0] pick_event(input bit editing);
    int r;
    r = $urandom_range(0, 99);
    if (editing) begin
      if (r < 40) return REQ_INC;
      if (r < 65) return REQ_FLASH;
      if (r < 90) return REQ_REFRESH;
      if (r < 95) return REQ_MODE;
      return REQ_TIME;
    end
    if (r < 55) return REQ_TIME;
    if (r < 80) return REQ_REFRESH;
    if (r < 88) return REQ_FLASH;
    if (r < 94) return REQ_INC;
    return REQ_MODE;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------
  // Ready follows random short stalls, or one long hold-off when asked.
  initial begin : drain_results
    int stall;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
        res_ch.ready <= 1'b1;
      end else if (idling && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 3);
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string what, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (pending_displays.size() == 0) begin
        $display("%0t: display transfer with nothing owed", $time);
        errors++;
      end else begin
        want = pending_displays.pop_front();
        checked_count++;
        check_field("digit_enable", 8'(want.digit_enable), 8'(res_ch.digit_enable));
        check_field("segment_pattern", want.segment_pattern, res_ch.segment_pattern);
        check_field("minutes_units", 8'(want.minutes_units), 8'(res_ch.minutes_units));
        check_field("minutes_tens", 8'(want.minutes_tens), 8'(res_ch.minutes_tens));
        check_field("hours_units", 8'(want.hours_units), 8'(res_ch.hours_units));
        check_field("hours_tens", 8'(want.hours_tens), 8'(res_ch.hours_tens));
        check_field("in_setting_mode", 8'(want.in_setting_mode),
                    8'(res_ch.in_setting_mode));
        check_field("selected_position", 8'(want.selected_position),
                    8'(res_ch.selected_position));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset limits: one fast tick advances, one slow tick does not; flash and
  // increment are ignored outside setting mode, spare codes change nothing.
  task automatic test_reset_state();
    int c;
    send_event(REQ_TIME, 1'b1);
    send_event(REQ_TIME, 1'b0);
    send_event(REQ_FLASH, 1'b0);
    send_event(REQ_INC, 1'b1);
    for (c = REQ_SPARE_FIRST; c <= REQ_SPARE_LAST; c++) send_event(3'(c), 1'(c));
    quiesce();
  endtask

  // Full scan cycle at one refresh per step; the point lights on hours units.
  task automatic test_scan_cycle();
    set_limits(16'd2, 16'd1, 16'd1, 16'd1);
    repeat (4) send_event(REQ_REFRESH, 1'b0);
    quiesce();
  endtask

  // Walk every edit position: paused counting, a scan step with a flash reveal,
  // an increment that wraps past 23 hours, and leaving at minutes units.
  task automatic test_setting_walk();
    send_event(REQ_MODE, 1'b0);
    send_event(REQ_TIME, 1'b1);
    send_event(REQ_INC, 1'b0);
    send_event(REQ_FLASH, 1'b0);
    send_event(REQ_REFRESH, 1'b0);
    send_event(REQ_MODE, 1'b0);
    send_event(REQ_INC, 1'b0);
    send_event(REQ_INC, 1'b0);
    send_event(REQ_MODE, 1'b1);
    send_event(REQ_INC, 1'b0);
    send_event(REQ_MODE, 1'b0);
    send_event(REQ_INC, 1'b1);
    send_event(REQ_MODE, 1'b0);
    quiesce();
  endtask

  // Set 23:59 by hand, then let time ticks carry through midnight.
  task automatic test_midnight_wrap();
    set_time(4'd2, 4'd3, 4'd5, 4'd9, 1'b0);
    repeat (3) send_event(REQ_TIME, 1'b1);
    quiesce();
  endtask

  // Flash ticks gathered in setting mode still reveal a digit after leaving.
  task automatic test_flash_leftover();
    set_limits(16'd2, 16'd1, 16'd1, 16'd3);
    send_event(REQ_MODE, 1'b0);
    repeat (3) send_event(REQ_FLASH, 1'b0);
    repeat (4) send_event(REQ_MODE, 1'b0);
    send_event(REQ_REFRESH, 1'b0);
    quiesce();
  endtask

  // With zero limits every tick fires and every scan step reveals a digit.
  task automatic test_zero_limits();
    set_limits(16'd0, 16'd0, 16'd0, 16'd0);
    send_event(REQ_TIME, 1'b0);
    send_event(REQ_TIME, 1'b1);
    send_event(REQ_REFRESH, 1'b0);
    send_event(REQ_REFRESH, 1'b1);
    quiesce();
  endtask

  // Pile flash ticks well past the limit; the count keeps climbing and the
  // next scan step still reveals the edited digit and clears the count.
  task automatic test_flash_ceiling();
    idling = 1'b0;
    set_limits(16'd30, 16'd1, 16'd2, 16'd40);
    send_event(REQ_MODE, 1'b0);
    repeat (FLASH_FLOOD) send_event(REQ_FLASH, 1'($urandom_range(0, 1)));
    repeat (2) send_event(REQ_REFRESH, 1'b0);
    repeat (4) send_event(REQ_MODE, 1'b0);
    quiesce();
    idling = 1'b1;
  endtask

  // Hold results off long enough that the block fills and stalls requests.
  task automatic test_backpressure();
    set_limits(16'd1, 16'd1, 16'd1, 16'd2);
    idling   = 1'b0;
    hold_off = 1'b1;
    repeat (24) send_event(pick_event(setting_on), 1'($urandom_range(0, 1)));
    quiesce();
    idling = 1'b1;
  endtask

  // Mostly well-formed episodes (set a time, run the clock, edit), some noise.
  task automatic run_mix(input int budget);
    int first;
    int n;
    logic [3:0] ht, hu, mt, mu;
    first = sent_count;
    while (sent_count - first < budget) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          ht = 4'($urandom_range(0, 2));
          hu = (ht == 4'd2) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 9));
          mt = 4'($urandom_range(0, 5));
          mu = 4'($urandom_range(0, 9));
          if ($urandom_range(0, 3) == 0) begin
            mt = 4'd5;
            mu = 4'd9;
          end
          set_time(ht, hu, mt, mu, 1'b1);
          n = $urandom_range(3, 15);
          repeat (n) send_event(pick_event(1'b0), 1'($urandom_range(0, 1)));
        end
        3, 4: begin
          if (!setting_on) send_event(REQ_MODE, 1'($urandom_range(0, 1)));
          n = $urandom_range(4, 16);
          repeat (n) send_event(pick_event(1'b1), 1'($urandom_range(0, 1)));
        end
        5, 6, 7: begin
          n = $urandom_range(5, 30);
          repeat (n) send_event(pick_event(1'b0), 1'($urandom_range(0, 1)));
        end
        default: begin
          n = $urandom_range(1, 8);
          repeat (n) send_event(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        end
      endcase
    end
  endtask

  // Several limit settings, extremes among them; the last phase runs without bubbles.
  task automatic test_random_traffic();
    int phase;
    for (phase = 0; phase < 5; phase++) begin
      quiesce();
      idling = (phase != 1 && phase != 4);
      case (phase)
        1: set_limits(16'd1, 16'd1, 16'd1, 16'd1);
        2: set_limits(16'd1023, 16'd1023, 16'd255, FLASH_MAX);
        default: set_limits(16'($urandom_range(1, 6)), 16'($urandom_range(1, 2)),
                            16'($urandom_range(1, 4)), 16'($urandom_range(1, 8)));
      endcase
      run_mix(PHASE_EVENTS);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    req_ch.valid            = 1'b0;
    req_ch.req_type         = REQ_TIME;
    req_ch.fast_button_held = 1'b0;
    cfg_write               = 1'b0;
    cfg_index               = CFG_SLOW_LIMIT;
    cfg_data                = '0;
    rst                     = 1'b1;
    idling                  = 1'b1;
    hold_off                = 1'b0;
    reset_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_scan_cycle();
    test_setting_walk();
    test_midnight_wrap();
    test_flash_leftover();
    test_zero_limits();
    test_flash_ceiling();
    test_backpressure();
    test_random_traffic();

    // Drain, then wait so that any stray transfer would show.
    quiesce();
    repeat (8) @(posedge clk);

    $display("Covered %0d request transfers and %0d display checks, %0d mismatches",
             sent_count, checked_count, errors);
    $display("Clock saw %0d minute steps, %0d wraps to 00:00, %0d scan steps, %0d reveals",
             minute_steps, midnight_wraps, scan_steps, flash_reveals);
    if (errors == 0) begin
      $display("multiplexed_seven_segment_clock_core test passed");
    end else begin
      $display("multiplexed_seven_segment_clock_core test failed");
    end
    $finish;
  end

endmodule
